// ===== src/bb_pkg.sv =====
// ----------------------------------------------------------------------------
// Box blur package
// Shared types and constants for the 3x3 box-mean filter core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bb_pkg;

   // Fixed widths of the frame counters and of the neighbourhood sums.
   localparam int CNT_W        = 24;
   localparam int ROW_W        = CNT_W - 1;
   localparam int SUM_W        = 12;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   // Depths of the command queue and of the result queue.
   localparam int CQ_DEPTH = 4;
   localparam int OQ_DEPTH = 4;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_code_type;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      cmd_code_type cmd;
      logic [7:0]   red_in;
      logic [7:0]   green_in;
      logic [7:0]   blue_in;
      logic [7:0]   alpha_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
      logic       frame_last;
   } rsp_type;

   // One classified item handed from the front end to the filter pipeline.
   typedef struct packed {
      pixel_type pixel;
      logic      emit;
      logic      top_edge;
      logic      bottom_edge;
      logic      left_edge;
      logic      right_edge;
      logic      last;
   } cmd_type;

endpackage

`default_nettype wire

// ===== src/bb_fifo.sv =====
// ----------------------------------------------------------------------------
// Box blur queue
// Small first-in first-out queue of register storage, head shown directly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bb_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 4
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_data,
   output logic          full,
   input  wire logic     pop,
   output item_type      pop_data,
   output logic          empty
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   item_type          store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      full     = (fill_ff == FILL_W'(DEPTH));
      empty    = (fill_ff == '0);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_data = store_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + FILL_W'(do_push) - FILL_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/bb_csr.sv =====
// ----------------------------------------------------------------------------
// Box blur configuration registers
// Frame size registers, clamped size and pixel total, and a serial divider
// that rebuilds the output position after the frame size changes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bb_csr #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire bb_pkg::csr_index_type                 csr_index,
   input  wire logic [bb_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  wire logic [bb_pkg::CNT_W-1:0]              emitted,
   output logic [$clog2(MAX_WIDTH+1)-1:0]             img_w,
   output logic [$clog2(MAX_HEIGHT+1)-1:0]            img_h,
   output logic [$clog2(MAX_WIDTH+1)+$clog2(MAX_HEIGHT+1)-1:0] img_total,
   output logic                                       recalc_busy,
   output logic                                       pos_load,
   output logic [$clog2(MAX_WIDTH)-1:0]               pos_col,
   output logic [bb_pkg::ROW_W-1:0]                   pos_row
);

   import bb_pkg::*;

   localparam int WW        = $clog2(MAX_WIDTH + 1);
   localparam int HW        = $clog2(MAX_HEIGHT + 1);
   localparam int TW        = WW + HW;
   localparam int CW        = $clog2(MAX_WIDTH);
   localparam int STEP_W    = $clog2(CNT_W);
   localparam int RST_W     = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
   localparam int RST_H     = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;
   localparam int RST_TOTAL = RST_W * RST_H;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [TW-1:0]           total_ff;
   logic [WW-1:0]           rem_ff, rem_in;
   logic [CNT_W-1:0]        quo_ff, quo_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [WW:0]             trial;
   logic                    write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   // Registers are used clamped to the supported frame size.
   always_comb begin
      if (width_ff < WIDTH_REG_W'(2)) begin
         img_w = WW'(2);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         img_w = WW'(MAX_WIDTH);
      end else begin
         img_w = WW'(width_ff);
      end
      if (height_ff < HEIGHT_REG_W'(2)) begin
         img_h = HW'(2);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         img_h = HW'(MAX_HEIGHT);
      end else begin
         img_h = HW'(height_ff);
      end
   end

   assign img_total   = total_ff;
   assign recalc_busy = (state_ff != ST_IDLE);
   assign pos_load    = (state_ff == ST_DONE);
   assign pos_col     = CW'(rem_ff);
   assign pos_row     = quo_ff[ROW_W-1:0];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (write) begin
         case (csr_index)
            REG_IMAGE_WIDTH: begin
               width_in = csr_wdata[WIDTH_REG_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
               height_in = csr_wdata[HEIGHT_REG_W-1:0];
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   // Restoring division of the emitted count by the new width, one
   // quotient bit a cycle: the remainder is the column, the quotient the row.
   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      trial    = {rem_ff, quo_ff[CNT_W-1]};
      case (state_ff)
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         ST_LOAD: begin
            rem_in   = '0;
            quo_in   = emitted;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (trial >= {1'b0, img_w}) begin
               rem_in = WW'(trial - {1'b0, img_w});
               quo_in = {quo_ff[CNT_W-2:0], 1'b1};
            end else begin
               rem_in = trial[WW-1:0];
               quo_in = {quo_ff[CNT_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CNT_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (write) begin
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         width_ff  <= WIDTH_REG_W'(RESET_WIDTH);
         height_ff <= HEIGHT_REG_W'(RESET_HEIGHT);
         total_ff  <= TW'(RST_TOTAL);
         step_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         total_ff  <= TW'(img_w) * TW'(img_h);
         step_ff   <= step_in;
         rem_ff    <= rem_in;
         quo_ff    <= quo_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/bb_front.sv =====
// ----------------------------------------------------------------------------
// Box blur front end
// Accepts beats, drops drains inside the frame, tracks frame position and
// tags each kept beat with its output position before queueing it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bb_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_push,
   input  wire bb_pkg::req_type                       req_data,
   output logic                                       req_full,
   input  wire logic                                  cq_full,
   output logic                                       cq_push,
   output bb_pkg::cmd_type                            cq_data,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]        img_w,
   input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]       img_h,
   input  wire logic [$clog2(MAX_WIDTH+1)+$clog2(MAX_HEIGHT+1)-1:0] img_total,
   input  wire logic                                  recalc_busy,
   input  wire logic                                  pos_load,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]          pos_col,
   input  wire logic [bb_pkg::ROW_W-1:0]              pos_row,
   output logic [bb_pkg::CNT_W-1:0]                   emitted
);

   import bb_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic [CNT_W-1:0] seen_ff, seen_in;
   logic [CNT_W-1:0] emitted_ff, emitted_in;
   logic [CW-1:0]    ocol_ff, ocol_in;
   logic [ROW_W-1:0] orow_ff, orow_in;
   logic             accept;
   logic             in_frame;
   logic             take;
   logic             emit;
   logic             last;

   assign emitted = emitted_ff;

   always_comb begin
      req_full = cq_full || recalc_busy;
      accept   = req_push && !req_full;
      in_frame = 32'(seen_ff) < 32'(img_total);
      take     = accept && !(in_frame && (req_data.cmd == CMD_DRAIN));
      emit     = 32'(seen_ff) >= (32'(img_w) + 32'd1);
      last     = (32'(emitted_ff) + 32'd1) >= 32'(img_total);

      cq_push = take;
      // Past the frame's last pixel every beat counts as a drain with no data.
      if (in_frame) begin
         cq_data.pixel.red   = req_data.red_in;
         cq_data.pixel.green = req_data.green_in;
         cq_data.pixel.blue  = req_data.blue_in;
         cq_data.pixel.alpha = req_data.alpha_in;
      end else begin
         cq_data.pixel = '0;
      end
      cq_data.emit        = emit;
      cq_data.top_edge    = (orow_ff == '0);
      cq_data.bottom_edge = 32'(orow_ff) >= (32'(img_h) - 32'd1);
      cq_data.left_edge   = (ocol_ff == '0);
      cq_data.right_edge  = (32'(ocol_ff) + 32'd1) >= 32'(img_w);
      cq_data.last        = last;

      seen_in    = seen_ff;
      emitted_in = emitted_ff;
      ocol_in    = ocol_ff;
      orow_in    = orow_ff;
      if (pos_load) begin
         ocol_in = pos_col;
         orow_in = pos_row;
      end
      if (take) begin
         seen_in = seen_ff + 1'b1;
         if (emit) begin
            if (last) begin
               seen_in    = '0;
               emitted_in = '0;
               ocol_in    = '0;
               orow_in    = '0;
            end else begin
               emitted_in = emitted_ff + 1'b1;
               if ((32'(ocol_ff) + 32'd1) >= 32'(img_w)) begin
                  ocol_in = '0;
                  orow_in = orow_ff + 1'b1;
               end else begin
                  ocol_in = ocol_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         emitted_ff <= '0;
         ocol_ff    <= '0;
         orow_ff    <= '0;
      end else begin
         seen_ff    <= seen_in;
         emitted_ff <= emitted_in;
         ocol_ff    <= ocol_in;
         orow_ff    <= orow_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/bb_back.sv =====
// ----------------------------------------------------------------------------
// Box blur back end
// Line store, 3x3 window, masked sums and constant division, feeding a
// result queue whose free slots are reserved before a beat is issued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bb_back #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           cq_empty,
   input  wire bb_pkg::cmd_type                cq_data,
   output logic                                cq_pop,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0] img_w,
   input  wire logic                           rsp_pop,
   output logic                                rsp_empty,
   output bb_pkg::rsp_type                     rsp_data
);

   import bb_pkg::*;

   localparam int CW          = $clog2(MAX_WIDTH);
   localparam int RESV_W      = $clog2(OQ_DEPTH + 1);
   localparam int RECIP_W     = 14;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_9 = 14'd7282;
   localparam logic [RECIP_W-1:0] RECIP_6 = 14'd10923;

   typedef enum logic [1:0] {
      DIV_BY_4,
      DIV_BY_6,
      DIV_BY_9
   } div_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type lower;
   } line_pair_type;

   // Truncated mean by reciprocal multiplication; exact for sums up to 9 * 255.
   function automatic logic [7:0] mean_of(input logic [SUM_W-1:0] sum,
                                          input div_type          div);
      logic [PROD_W-1:0] prod;
      logic [7:0]        mean;
      prod = '0;
      case (div)
         DIV_BY_9: begin
            prod = PROD_W'(sum) * PROD_W'(RECIP_9);
            mean = prod[RECIP_SHIFT +: 8];
         end
         DIV_BY_6: begin
            prod = PROD_W'(sum) * PROD_W'(RECIP_6);
            mean = prod[RECIP_SHIFT +: 8];
         end
         DIV_BY_4: begin
            mean = sum[9:2];
         end
         default: begin
            mean = '0;
         end
      endcase
      return mean;
   endfunction

   line_pair_type     line_mem [MAX_WIDTH];
   line_pair_type     rd_pair_ff;
   logic [CW-1:0]     col_ff, col_in;
   logic [RESV_W-1:0] resv_ff, resv_in;
   logic              issue;
   logic              rsp_take;

   logic              s1_valid_ff;
   cmd_type           s1_cmd_ff;
   logic [CW-1:0]     s1_col_ff;
   pixel_type         win_ff [3][3];

   logic              s2_valid_ff;
   cmd_type           s2_cmd_ff;
   logic [2:0]        row_en;
   logic [2:0]        col_en;
   logic [SUM_W-1:0]  sum_r, sum_g, sum_b;
   div_type           div_code;

   logic              s3_valid_ff;
   logic [SUM_W-1:0]  s3_sum_r_ff, s3_sum_g_ff, s3_sum_b_ff;
   div_type           s3_div_ff;
   logic [7:0]        s3_alpha_ff;
   logic              s3_last_ff;
   rsp_type           oq_data;

   // Issue stage: a beat that gives a result goes only with a free slot,
   // and a slot that a pop frees in this cycle counts as free.
   always_comb begin
      rsp_take = rsp_pop && !rsp_empty;
      issue    = !cq_empty && (!cq_data.emit || (resv_ff < RESV_W'(OQ_DEPTH)) || rsp_take);
      cq_pop   = issue;
      resv_in  = resv_ff + RESV_W'(issue && cq_data.emit) - RESV_W'(rsp_take);
      col_in   = col_ff;
      if (issue) begin
         if (cq_data.emit && cq_data.last) begin
            col_in = '0;
         end else if ((32'(col_ff) + 32'd1) >= 32'(img_w)) begin
            col_in = '0;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_pair_ff <= line_mem[col_ff];
      end
      if (s1_valid_ff) begin
         line_mem[s1_col_ff] <= '{upper: rd_pair_ff.lower, lower: s1_cmd_ff.pixel};
      end
   end

   // Masked 3x3 sums; row 0 is two lines back, column 2 the newest.
   always_comb begin
      row_en = {!s2_cmd_ff.bottom_edge, 1'b1, !s2_cmd_ff.top_edge};
      col_en = {!s2_cmd_ff.right_edge, 1'b1, !s2_cmd_ff.left_edge};
      sum_r  = '0;
      sum_g  = '0;
      sum_b  = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (row_en[r] && col_en[c]) begin
               sum_r = sum_r + SUM_W'(win_ff[r][c].red);
               sum_g = sum_g + SUM_W'(win_ff[r][c].green);
               sum_b = sum_b + SUM_W'(win_ff[r][c].blue);
            end
         end
      end
      if (row_en[0] && row_en[2] && col_en[0] && col_en[2]) begin
         div_code = DIV_BY_9;
      end else if ((row_en[0] && row_en[2]) || (col_en[0] && col_en[2])) begin
         div_code = DIV_BY_6;
      end else begin
         div_code = DIV_BY_4;
      end
   end

   always_comb begin
      oq_data.red_out    = mean_of(s3_sum_r_ff, s3_div_ff);
      oq_data.green_out  = mean_of(s3_sum_g_ff, s3_div_ff);
      oq_data.blue_out   = mean_of(s3_sum_b_ff, s3_div_ff);
      oq_data.alpha_out  = s3_alpha_ff;
      oq_data.frame_last = s3_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         resv_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         col_ff      <= col_in;
         resv_ff     <= resv_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff && s1_cmd_ff.emit;
         s3_valid_ff <= s2_valid_ff;
         if (s1_valid_ff) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
            end
            win_ff[0][2] <= rd_pair_ff.upper;
            win_ff[1][2] <= rd_pair_ff.lower;
            win_ff[2][2] <= s1_cmd_ff.pixel;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff   <= cq_data;
      s1_col_ff   <= col_ff;
      s2_cmd_ff   <= s1_cmd_ff;
      s3_sum_r_ff <= sum_r;
      s3_sum_g_ff <= sum_g;
      s3_sum_b_ff <= sum_b;
      s3_div_ff   <= div_code;
      s3_alpha_ff <= win_ff[1][1].alpha;
      s3_last_ff  <= s2_cmd_ff.last;
   end

   bb_fifo #(
      .item_type (rsp_type),
      .DEPTH     (OQ_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_valid_ff),
      .push_data (oq_data),
      .full      (),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

`default_nettype wire

// ===== src/box_blur_3x3_rgb_core.sv =====
// ----------------------------------------------------------------------------
// Box blur 3x3 RGB core
// Raster-order RGBA stream in, 3x3 neighbourhood mean of red, green and blue
// out, with alpha passed through and a frame_last marker on the final pixel.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                              Beat taken when
//   -------   --------------------------------   ------------------------
//   request   req_push, req_full, req_data       req_push && !req_full
//   response  rsp_empty, rsp_pop, rsp_data       rsp_pop && !rsp_empty
//   config    csr_valid, csr_ready, csr_index,   csr_valid && csr_ready
//             csr_wdata
//
// One request beat can be taken every clock cycle while req_full is low. A result
// passes through the command queue, line store read, window update, sum and
// reciprocal multiply before it enters the response queue.
// After a configuration write the request side stalls while a serial divider,
// one quotient bit a cycle, rebuilds the output position.
// Reset is synchronous and clears all control state; the line store is not
// cleared, since entries never written only feed neighbours outside the image.
// The response queue reserves a slot before a beat is issued to the filter
// pipeline, so a stalled response side backs up into the command queue and
// then into req_full, and nothing is dropped.
//
`timescale 1ns / 1ps
`default_nettype none

module box_blur_3x3_rgb_core #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   input  wire bb_pkg::req_type               req_data,
   output logic                               req_full,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output bb_pkg::rsp_type                    rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire bb_pkg::csr_index_type         csr_index,
   input  wire logic [bb_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import bb_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int TW = WW + HW;
   localparam int CW = $clog2(MAX_WIDTH);

   // Clamped frame size and pixel count; the width goes to both halves.
   logic [WW-1:0]    img_w;
   logic [HW-1:0]    img_h;
   logic [TW-1:0]    img_total;

   // Position rebuild after a size change.
   logic             recalc_busy;
   logic             pos_load;
   logic [CW-1:0]    pos_col;
   logic [ROW_W-1:0] pos_row;
   logic [CNT_W-1:0] emitted;

   // Command queue between the front end and the filter pipeline.
   logic             cq_push;
   logic             cq_full;
   cmd_type          cq_in;
   logic             cq_pop;
   logic             cq_empty;
   cmd_type          cq_head;

   bb_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .emitted     (emitted),
      .img_w       (img_w),
      .img_h       (img_h),
      .img_total   (img_total),
      .recalc_busy (recalc_busy),
      .pos_load    (pos_load),
      .pos_col     (pos_col),
      .pos_row     (pos_row)
   );

   // The front end classifies each beat: drains inside the frame vanish here,
   // everything else is tagged with whether it releases a result and where
   // that result sits in the frame (edges select the divisor).
   bb_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_data    (req_data),
      .req_full    (req_full),
      .cq_full     (cq_full),
      .cq_push     (cq_push),
      .cq_data     (cq_in),
      .img_w       (img_w),
      .img_h       (img_h),
      .img_total   (img_total),
      .recalc_busy (recalc_busy),
      .pos_load    (pos_load),
      .pos_col     (pos_col),
      .pos_row     (pos_row),
      .emitted     (emitted)
   );

   bb_fifo #(
      .item_type (cmd_type),
      .DEPTH     (CQ_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cq_push),
      .push_data (cq_in),
      .full      (cq_full),
      .pop       (cq_pop),
      .pop_data  (cq_head),
      .empty     (cq_empty)
   );

   // The back end owns the line store and the window, so it never stalls
   // mid-pipeline; it only holds off issuing when the result queue is booked.
   bb_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cq_empty  (cq_empty),
      .cq_data   (cq_head),
      .cq_pop    (cq_pop),
      .img_w     (img_w),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
